/* hdl/tte_pkg.sv */
// ----------------------------------------------------------------------------
// tte_pkg
// Shared types, codes and constants of the character-cell terminal engine.
// ----------------------------------------------------------------------------
package tte_pkg;

  localparam int DEF_MAX_LINES    = 32;
  localparam int DEF_MAX_COLS     = 128;
  localparam int LINE_COUNT_RST   = 24;
  localparam int COLUMN_COUNT_RST = 80;

  localparam int BYTE_W     = 8;
  localparam int ROW_FW     = 5;
  localparam int COL_FW     = 7;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam int LC_W       = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_LINE_COUNT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 1'b1;

  localparam logic OP_FEED = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [BYTE_W-1:0] CH_LF        = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR        = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_BEL       = 8'h07;
  localparam logic [BYTE_W-1:0] CH_ESC       = 8'h1B;
  localparam logic [BYTE_W-1:0] CH_LBRACKET  = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_S         = 8'h73;
  localparam logic [BYTE_W-1:0] CH_U         = 8'h75;
  localparam logic [BYTE_W-1:0] CH_TWO       = 8'h32;
  localparam logic [BYTE_W-1:0] CH_J         = 8'h4A;
  localparam logic [BYTE_W-1:0] CH_K         = 8'h4B;
  localparam logic [BYTE_W-1:0] CH_PRINT_LO  = 8'h20;
  localparam logic [BYTE_W-1:0] CH_PRINT_HI  = 8'h7E;

  typedef enum logic [1:0] {
    ESC_IDLE,
    ESC_SEEN,
    ESC_CSI,
    ESC_CSI2
  } esc_phase_t;

  typedef enum logic [3:0] {
    CK_NOP,
    CK_READ,
    CK_PRINT,
    CK_LF,
    CK_CR,
    CK_BEL,
    CK_SAVE,
    CK_RESTORE,
    CK_CLR_SCREEN,
    CK_CLR_LINE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [BYTE_W-1:0] ch;
    logic [ROW_FW-1:0] rd_row;
    logic [COL_FW-1:0] rd_col;
  } cmd_t;

  typedef struct packed {
    logic              scrolled;
    logic              bell;
    logic [COL_FW-1:0] cursor_col;
    logic [ROW_FW-1:0] cursor_row;
    logic [BYTE_W-1:0] cell_char;
  } res_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_FILL
  } back_state_t;

endpackage

/* hdl/tte_front.sv */
// ----------------------------------------------------------------------------
// tte_front
// Input side: takes stream transfers, runs the escape decoder and turns each
// item into one command for the back end.
// ----------------------------------------------------------------------------
module tte_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        clr,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [tte_pkg::IN_DATA_W-1:0] in_tdata,  // byte_in, read_row, read_col
  input  logic                        in_tuser,  // opcode
  output tte_pkg::cmd_t               cmd,
  output logic                        cmd_vld,
  input  logic                        cmd_rdy
);
  import tte_pkg::*;

  esc_phase_t        phase_r;
  esc_phase_t        phase_nxt;
  logic [BYTE_W-1:0] b;
  logic              take;

  assign b         = in_tdata[BYTE_W-1:0];
  assign in_tready = cmd_rdy;
  assign cmd_vld   = in_tvalid;
  assign take      = in_tvalid && cmd_rdy;

  always_comb begin
    cmd.kind   = CK_NOP;
    cmd.ch     = b;
    cmd.rd_row = in_tdata[BYTE_W+ROW_FW-1:BYTE_W];
    cmd.rd_col = in_tdata[BYTE_W+ROW_FW+COL_FW-1:BYTE_W+ROW_FW];
    phase_nxt  = phase_r;
    if (in_tuser == OP_READ) begin
      cmd.kind = CK_READ;
    end else begin
      unique case (phase_r)
        ESC_SEEN: begin
          phase_nxt = (b == CH_LBRACKET) ? ESC_CSI : ESC_IDLE;
        end
        ESC_CSI: begin
          phase_nxt = ESC_IDLE;
          if (b == CH_S) begin
            cmd.kind = CK_SAVE;
          end else if (b == CH_U) begin
            cmd.kind = CK_RESTORE;
          end else if (b == CH_TWO) begin
            phase_nxt = ESC_CSI2;
          end else if (b == CH_K) begin
            cmd.kind = CK_CLR_LINE;
          end
        end
        ESC_CSI2: begin
          phase_nxt = ESC_IDLE;
          if (b == CH_J) begin
            cmd.kind = CK_CLR_SCREEN;
          end
        end
        default: begin
          if (b >= CH_PRINT_LO && b <= CH_PRINT_HI) begin
            cmd.kind = CK_PRINT;
          end else if (b == CH_LF) begin
            cmd.kind = CK_LF;
          end else if (b == CH_CR) begin
            cmd.kind = CK_CR;
          end else if (b == CH_BEL) begin
            cmd.kind = CK_BEL;
          end else if (b == CH_ESC) begin
            phase_nxt = ESC_SEEN;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      phase_r <= ESC_IDLE;
    end else if (take) begin
      phase_r <= phase_nxt;
    end
  end

endmodule

/* hdl/tte_cmd_queue.sv */
// ----------------------------------------------------------------------------
// tte_cmd_queue
// Two-entry command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module tte_cmd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  tte_pkg::cmd_t wr_cmd,
  input  logic          wr_vld,
  output logic          wr_rdy,
  output tte_pkg::cmd_t rd_cmd,
  output logic          rd_vld,
  input  logic          rd_rdy
);
  import tte_pkg::*;

  localparam int QDEPTH = 2;
  localparam int PW     = $clog2(QDEPTH);
  localparam int CW     = $clog2(QDEPTH + 1);

  cmd_t          q_r [QDEPTH];
  logic [PW-1:0] wp_r;
  logic [PW-1:0] rp_r;
  logic [CW-1:0] cnt_r;
  logic [PW-1:0] wp_nxt;
  logic [PW-1:0] rp_nxt;
  logic [CW-1:0] cnt_nxt;
  logic          push;
  logic          pop;

  assign wr_rdy = cnt_r != CW'(QDEPTH);
  assign rd_vld = cnt_r != '0;
  assign rd_cmd = q_r[rp_r];
  assign push   = wr_vld && wr_rdy;
  assign pop    = rd_vld && rd_rdy;

  always_comb begin
    wp_nxt  = push ? ((wp_r == PW'(QDEPTH - 1)) ? '0 : wp_r + PW'(1)) : wp_r;
    rp_nxt  = pop  ? ((rp_r == PW'(QDEPTH - 1)) ? '0 : rp_r + PW'(1)) : rp_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= wr_cmd;
    end
  end

endmodule

/* hdl/tte_back.sv */
// ----------------------------------------------------------------------------
// tte_back
// Execution side: cursor, saved cursor, screen store with a rotating line
// base and per-line valid bits, and the result register.
// ----------------------------------------------------------------------------
module tte_back #(
  parameter int MAX_LINES = tte_pkg::DEF_MAX_LINES,
  parameter int MAX_COLS  = tte_pkg::DEF_MAX_COLS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                clr,
  input  logic [$clog2(MAX_LINES+1)-1:0]      nl,
  input  logic [$clog2(MAX_COLS+1)-1:0]       nc,
  input  tte_pkg::cmd_t                       cmd,
  input  logic                                cmd_vld,
  output logic                                cmd_rdy,
  output tte_pkg::res_t                       res,
  output logic                                res_vld,
  input  logic                                res_rdy
);
  import tte_pkg::*;

  localparam int RIW   = $clog2(MAX_LINES);
  localparam int CIW   = $clog2(MAX_COLS);
  localparam int DEPTH = MAX_LINES * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CMPW  = 10;
  localparam logic [AW-1:0] COLS_A = AW'(MAX_COLS);

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rd_data_r;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;

  back_state_t       state_r;
  back_state_t       state_nxt;
  logic [RIW-1:0]    cur_row_r, cur_row_nxt;
  logic [CIW-1:0]    cur_col_r, cur_col_nxt;
  logic [RIW-1:0]    sav_row_r, sav_row_nxt;
  logic [CIW-1:0]    sav_col_r, sav_col_nxt;
  logic              sav_vld_r, sav_vld_nxt;
  logic [RIW-1:0]    base_r, base_nxt;
  logic [MAX_LINES-1:0] row_vld_r, row_vld_nxt;
  logic [CIW-1:0]    fill_col_r, fill_col_nxt;
  logic [RIW-1:0]    fill_row_r, fill_row_nxt;
  logic [BYTE_W-1:0] fill_ch_r, fill_ch_nxt;
  logic              rd_hit_r, rd_hit_nxt;
  logic              out_vld_r, out_vld_nxt;
  res_t              out_res_r, out_res_nxt;

  logic              slot_free;
  logic              take;
  logic [RIW-1:0]    cur_phys;
  logic [RIW-1:0]    next_phys;
  logic [RIW-1:0]    rd_phys;
  logic              rd_in_range;
  logic              fill_last;
  logic              col_adv;
  logic              at_bottom;
  logic [RIW:0]      nl_ext;
  logic              ld;
  logic [BYTE_W-1:0] ld_cell;
  logic              ld_bell;
  logic              ld_scr;

  function automatic logic [RIW-1:0] phys_of(input logic [RIW-1:0] lr,
                                             input logic [RIW-1:0] base,
                                             input logic [RIW:0]   lines);
    logic [RIW:0] s;
    s = {1'b0, lr} + {1'b0, base};
    if (s >= lines) begin
      s = s - lines;
    end
    return s[RIW-1:0];
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [RIW-1:0] pr,
                                            input logic [CIW-1:0] c);
    return AW'(pr) * COLS_A + AW'(c);
  endfunction

  assign nl_ext      = (RIW+1)'(nl);
  assign slot_free   = !out_vld_r || res_rdy;
  assign take        = cmd_vld && slot_free && (state_r == BK_IDLE);
  assign cur_phys    = phys_of(cur_row_r, base_r, nl_ext);
  assign next_phys   = phys_of(cur_row_r + RIW'(1), base_r, nl_ext);
  assign rd_phys     = phys_of(RIW'(cmd.rd_row), base_r, nl_ext);
  assign rd_in_range = (CMPW'(cmd.rd_row) < CMPW'(nl)) && (CMPW'(cmd.rd_col) < CMPW'(nc));
  assign fill_last   = ((CIW+1)'(fill_col_r) + (CIW+1)'(1)) == (CIW+1)'(nc);
  assign col_adv     = ((CIW+1)'(cur_col_r) + (CIW+1)'(1)) < (CIW+1)'(nc);
  assign at_bottom   = ((RIW+1)'(cur_row_r) + (RIW+1)'(1)) >= nl_ext;
  assign cmd_rdy     = take;
  assign res         = out_res_r;
  assign res_vld     = out_vld_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (take) begin
          if (cmd.kind == CK_READ) begin
            state_nxt = BK_READ;
          end else if (cmd.kind == CK_PRINT && !row_vld_r[cur_phys]) begin
            state_nxt = BK_FILL;
          end
        end
      end
      BK_READ: begin
        state_nxt = BK_IDLE;
      end
      BK_FILL: begin
        if (fill_last) begin
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    cur_row_nxt  = cur_row_r;
    cur_col_nxt  = cur_col_r;
    sav_row_nxt  = sav_row_r;
    sav_col_nxt  = sav_col_r;
    sav_vld_nxt  = sav_vld_r;
    base_nxt     = base_r;
    row_vld_nxt  = row_vld_r;
    fill_col_nxt = fill_col_r;
    fill_row_nxt = fill_row_r;
    fill_ch_nxt  = fill_ch_r;
    rd_hit_nxt   = rd_hit_r;
    mem_we       = 1'b0;
    mem_waddr    = addr_of(cur_phys, cur_col_r);
    mem_wdata    = cmd.ch;
    mem_raddr    = addr_of(rd_phys, CIW'(cmd.rd_col));
    ld           = 1'b0;
    ld_cell      = '0;
    ld_bell      = 1'b0;
    ld_scr       = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (take) begin
          unique case (cmd.kind)
            CK_READ: begin
              rd_hit_nxt = rd_in_range && row_vld_r[rd_phys];
            end
            CK_PRINT: begin
              if (row_vld_r[cur_phys]) begin
                mem_we = 1'b1;
                ld     = 1'b1;
                if (col_adv) begin
                  cur_col_nxt = cur_col_r + CIW'(1);
                end
              end else begin
                fill_row_nxt = cur_phys;
                fill_col_nxt = '0;
                fill_ch_nxt  = cmd.ch;
              end
            end
            CK_LF: begin
              ld = 1'b1;
              if (at_bottom) begin
                ld_scr              = 1'b1;
                cur_row_nxt         = RIW'(nl_ext - (RIW+1)'(1));
                base_nxt            = ((RIW+1)'(base_r) + (RIW+1)'(1) == nl_ext) ?
                                      '0 : base_r + RIW'(1);
                row_vld_nxt[base_r] = 1'b0;
              end else begin
                cur_row_nxt            = cur_row_r + RIW'(1);
                row_vld_nxt[next_phys] = 1'b0;
              end
            end
            CK_CR: begin
              ld          = 1'b1;
              cur_col_nxt = '0;
            end
            CK_BEL: begin
              ld      = 1'b1;
              ld_bell = 1'b1;
            end
            CK_SAVE: begin
              ld          = 1'b1;
              sav_row_nxt = cur_row_r;
              sav_col_nxt = cur_col_r;
              sav_vld_nxt = 1'b1;
            end
            CK_RESTORE: begin
              ld = 1'b1;
              if (sav_vld_r) begin
                cur_row_nxt = sav_row_r;
                cur_col_nxt = sav_col_r;
                sav_vld_nxt = 1'b0;
              end
            end
            CK_CLR_SCREEN: begin
              ld          = 1'b1;
              row_vld_nxt = '0;
              cur_row_nxt = '0;
              cur_col_nxt = '0;
            end
            CK_CLR_LINE: begin
              ld                    = 1'b1;
              row_vld_nxt[cur_phys] = 1'b0;
            end
            default: begin
              ld = 1'b1;
            end
          endcase
        end
      end
      BK_READ: begin
        ld      = 1'b1;
        ld_cell = rd_hit_r ? rd_data_r : '0;
      end
      BK_FILL: begin
        mem_we       = 1'b1;
        mem_waddr    = addr_of(fill_row_r, fill_col_r);
        mem_wdata    = (fill_col_r == cur_col_r) ? fill_ch_r : '0;
        fill_col_nxt = fill_col_r + CIW'(1);
        if (fill_last) begin
          ld                      = 1'b1;
          row_vld_nxt[fill_row_r] = 1'b1;
          if (col_adv) begin
            cur_col_nxt = cur_col_r + CIW'(1);
          end
        end
      end
      default: begin
        ld = 1'b0;
      end
    endcase
    if (clr) begin
      cur_row_nxt = '0;
      cur_col_nxt = '0;
      sav_vld_nxt = 1'b0;
      base_nxt    = '0;
      row_vld_nxt = '0;
    end
    out_res_nxt.cell_char  = ld_cell;
    out_res_nxt.cursor_row = ROW_FW'(cur_row_nxt);
    out_res_nxt.cursor_col = COL_FW'(cur_col_nxt);
    out_res_nxt.bell       = ld_bell;
    out_res_nxt.scrolled   = ld_scr;
    if (!ld) begin
      out_res_nxt = out_res_r;
    end
    out_vld_nxt = ld ? 1'b1 : (res_rdy ? 1'b0 : out_vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BK_IDLE;
      cur_row_r <= '0;
      cur_col_r <= '0;
      sav_row_r <= '0;
      sav_col_r <= '0;
      sav_vld_r <= 1'b0;
      base_r    <= '0;
      row_vld_r <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cur_row_r <= cur_row_nxt;
      cur_col_r <= cur_col_nxt;
      sav_row_r <= sav_row_nxt;
      sav_col_r <= sav_col_nxt;
      sav_vld_r <= sav_vld_nxt;
      base_r    <= base_nxt;
      row_vld_r <= row_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fill_col_r <= fill_col_nxt;
    fill_row_r <= fill_row_nxt;
    fill_ch_r  <= fill_ch_nxt;
    rd_hit_r   <= rd_hit_nxt;
    out_res_r  <= out_res_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

endmodule

/* hdl/text_terminal_char_engine_unit.sv */
// ----------------------------------------------------------------------------
// text_terminal_char_engine_unit
// Character-cell terminal engine with a small ANSI escape subset.
//
// Input stream: each transfer either feeds one terminal byte or reads one
// screen cell; every transfer yields exactly one result transfer carrying
// the cell, the cursor after the item, and the bell and scroll flags.
// Configuration writes set the line and column counts and clear the screen;
// issue them only while no item is in flight.
// Each item is registered in the command queue, then in the result register;
// a read also passes the registered store port, and a printable byte on a
// cleared line zero-fills that line first. Throughput: one item per cycle
// for control bytes, clears and scrolls, which only flip per-line valid bits
// and a rotating line base, while the receiver is ready; a read or a printable
// byte on a cleared line holds off the next item until its result is loaded.
// Reset clears the screen at once through the line valid bits; no clearing
// pass is needed. When the receiver stalls, the result register holds, the
// two-entry command queue fills, and then the input side stalls.
// ----------------------------------------------------------------------------
module text_terminal_char_engine_unit #(
  parameter int MAX_LINES = tte_pkg::DEF_MAX_LINES,
  parameter int MAX_COLS  = tte_pkg::DEF_MAX_COLS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [tte_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tte_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [tte_pkg::IN_DATA_W-1:0]  in_tdata,   // byte_in, read_row, read_col
  input  logic                           in_tuser,   // opcode
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [tte_pkg::OUT_DATA_W-1:0] out_tdata   // cell_char, cursor_row_out,
                                                     // cursor_col_out, bell, scrolled
);
  import tte_pkg::*;

  localparam int NLW    = $clog2(MAX_LINES + 1);
  localparam int NCW    = $clog2(MAX_COLS + 1);
  localparam int CMPW   = 10;
  localparam int NL_RST = (LINE_COUNT_RST > MAX_LINES) ? MAX_LINES : LINE_COUNT_RST;
  localparam int NC_RST = (COLUMN_COUNT_RST > MAX_COLS) ? MAX_COLS : COLUMN_COUNT_RST;

  logic [NLW-1:0]  nl_r, nl_nxt;
  logic [NCW-1:0]  nc_r, nc_nxt;
  logic [LC_W-1:0] lc;

  cmd_t f_cmd;
  logic f_vld;
  logic f_rdy;
  cmd_t q_cmd;
  logic q_vld;
  logic q_rdy;
  res_t res;

  assign lc = cfg_wdata[LC_W-1:0];

  always_comb begin
    nl_nxt = nl_r;
    nc_nxt = nc_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_LINE_COUNT: begin
          if (lc < LC_W'(2)) begin
            nl_nxt = NLW'(2);
          end else if (CMPW'(lc) > CMPW'(MAX_LINES)) begin
            nl_nxt = NLW'(MAX_LINES);
          end else begin
            nl_nxt = NLW'(lc);
          end
        end
        CFG_COLUMN_COUNT: begin
          if (cfg_wdata < CFG_DATA_W'(2)) begin
            nc_nxt = NCW'(2);
          end else if (CMPW'(cfg_wdata) > CMPW'(MAX_COLS)) begin
            nc_nxt = NCW'(MAX_COLS);
          end else begin
            nc_nxt = NCW'(cfg_wdata);
          end
        end
        default: begin
          nl_nxt = nl_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nl_r <= NLW'(NL_RST);
      nc_r <= NCW'(NC_RST);
    end else begin
      nl_r <= nl_nxt;
      nc_r <= nc_nxt;
    end
  end

  tte_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr       (cfg_we),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd       (f_cmd),
    .cmd_vld   (f_vld),
    .cmd_rdy   (f_rdy)
  );

  tte_cmd_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_cmd (f_cmd),
    .wr_vld (f_vld),
    .wr_rdy (f_rdy),
    .rd_cmd (q_cmd),
    .rd_vld (q_vld),
    .rd_rdy (q_rdy)
  );

  tte_back #(
    .MAX_LINES (MAX_LINES),
    .MAX_COLS  (MAX_COLS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (cfg_we),
    .nl      (nl_r),
    .nc      (nc_r),
    .cmd     (q_cmd),
    .cmd_vld (q_vld),
    .cmd_rdy (q_rdy),
    .res     (res),
    .res_vld (out_tvalid),
    .res_rdy (out_tready)
  );

  assign out_tdata = {(OUT_DATA_W - $bits(res_t))'(0), res};

endmodule
